[hw/rtl/tpad_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point angle package
// Shared widths, angle constants, arctangent table and stage types for the
// CORDIC direction finder.
// ----------------------------------------------------------------------------
package tpad_pkg;

  // Number of CORDIC iterations, capped by the arctangent table length.
  localparam int CORDIC_STAGES = 16;
  // Significant bits of each coordinate word (at most the field width).
  localparam int COORD_BITS    = 16;

  localparam int FIELD_W     = 16;
  localparam int ANGLE_W     = 16;
  localparam int TABLE_LEN   = 24;
  localparam int NSTAGE      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int IDX_W       = $clog2(TABLE_LEN);
  localparam int GUARD_SHIFT = 24;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int MAG_W       = COORD_BITS;
  // Headroom for CORDIC gain (about 1.65) times the diagonal (about 1.41).
  localparam int XY_W        = MAG_W + GUARD_SHIFT + 3;
  localparam int ATAN_W      = 21;
  localparam int ACC_W       = 24;
  localparam int ACC_FRAC    = 8;

  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(128);
  localparam logic [ANGLE_W-1:0] DEG0       = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] DEG90      = ANGLE_W'(11520);
  localparam logic [ANGLE_W-1:0] DEG180     = ANGLE_W'(23040);
  localparam logic [ANGLE_W-1:0] DEG270     = ANGLE_W'(34560);
  localparam logic [ANGLE_W-1:0] DEG360     = ANGLE_W'(46080);

  // Quadrant handling carried alongside the CORDIC datapath.
  typedef struct packed {
    logic               fixed;        // result settled by an axis case
    logic [ANGLE_W-1:0] fixed_angle;
    logic               dx_neg;
    logic               dy_neg;
  } meta_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    meta_t                   meta;
  } cord_t;

  // atan(2^-i) in units of 2^-15 degree, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [IDX_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 21'd1474560;
      5'd1:    v = 21'd870484;
      5'd2:    v = 21'd459940;
      5'd3:    v = 21'd233473;
      5'd4:    v = 21'd117189;
      5'd5:    v = 21'd58652;
      5'd6:    v = 21'd29333;
      5'd7:    v = 21'd14667;
      5'd8:    v = 21'd7334;
      5'd9:    v = 21'd3667;
      5'd10:   v = 21'd1833;
      5'd11:   v = 21'd917;
      5'd12:   v = 21'd458;
      5'd13:   v = 21'd229;
      5'd14:   v = 21'd115;
      5'd15:   v = 21'd57;
      5'd16:   v = 21'd29;
      5'd17:   v = 21'd14;
      5'd18:   v = 21'd7;
      5'd19:   v = 21'd4;
      5'd20:   v = 21'd2;
      5'd21:   v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/two_point_angle_degrees_unit.sv]
`default_nettype none
// Path: an accepted point pair is registered in the front end, in each CORDIC
//   cell and in the back end. Throughput: one point pair per cycle unless the
//   output stalls, set by the fully unrolled cell row.
// Each stage holds its own word; stalls collapse bubbles stage by stage.
// Reset: synchronous; clears every stage valid bit, the datapath is not reset.
// ----------------------------------------------------------------------------
// Two-point angle unit
// Direction of the vector from a begin point to an end point, counter-
// clockwise from the positive x axis, in units of 1/128 degree, [0, 360).
// ----------------------------------------------------------------------------
module two_point_angle_degrees_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tpad_pkg::FIELD_W-1:0] begin_x,
  input  wire logic [tpad_pkg::FIELD_W-1:0] begin_y,
  input  wire logic [tpad_pkg::FIELD_W-1:0] end_x,
  input  wire logic [tpad_pkg::FIELD_W-1:0] end_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tpad_pkg::ANGLE_W-1:0]      angle
);

  // Word links: link 0 leaves the front end, link k leaves cell k-1.
  logic            link_valid [tpad_pkg::NSTAGE+1];
  logic            link_ready [tpad_pkg::NSTAGE+1];
  tpad_pkg::cord_t link_data  [tpad_pkg::NSTAGE+1];

  // Difference vector, axis cases and initial magnitudes.
  tpad_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .begin_x   (begin_x),
    .begin_y   (begin_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_data  (link_data[0])
  );

  // Row of CORDIC cells; each one does the iteration with its own shift and
  // arctangent entry, selected by a constant index.
  for (genvar g = 0; g < tpad_pkg::NSTAGE; g++) begin : g_cell
    tpad_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (tpad_pkg::IDX_W'(g)),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_data   (link_data[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_data  (link_data[g+1])
    );
  end

  // Round, clamp, fold into the quadrant and hold the result word.
  tpad_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[tpad_pkg::NSTAGE]),
    .in_ready  (link_ready[tpad_pkg::NSTAGE]),
    .in_data   (link_data[tpad_pkg::NSTAGE]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle)
  );

endmodule
`default_nettype wire

[hw/rtl/tpad_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point angle front end
// Forms the difference vector, settles the axis cases and loads the
// magnitudes into the first CORDIC word.
// ----------------------------------------------------------------------------
module tpad_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tpad_pkg::FIELD_W-1:0] begin_x,
  input  wire logic [tpad_pkg::FIELD_W-1:0] begin_y,
  input  wire logic [tpad_pkg::FIELD_W-1:0] end_x,
  input  wire logic [tpad_pkg::FIELD_W-1:0] end_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output tpad_pkg::cord_t                   out_data
);

  logic signed [tpad_pkg::COORD_BITS-1:0] bx, by, ex, ey;
  logic signed [tpad_pkg::DIFF_W-1:0]     dx, dy;
  logic [tpad_pkg::DIFF_W-1:0]            adx_full, ady_full;
  logic [tpad_pkg::MAG_W-1:0]             adx, ady;
  tpad_pkg::cord_t                        item_next;
  logic                                   vld;

  assign bx = begin_x[tpad_pkg::COORD_BITS-1:0];
  assign by = begin_y[tpad_pkg::COORD_BITS-1:0];
  assign ex = end_x[tpad_pkg::COORD_BITS-1:0];
  assign ey = end_y[tpad_pkg::COORD_BITS-1:0];

  assign dx = tpad_pkg::DIFF_W'(ex) - tpad_pkg::DIFF_W'(bx);
  assign dy = tpad_pkg::DIFF_W'(ey) - tpad_pkg::DIFF_W'(by);

  assign adx_full = dx[tpad_pkg::DIFF_W-1] ? -dx : dx;
  assign ady_full = dy[tpad_pkg::DIFF_W-1] ? -dy : dy;
  assign adx      = adx_full[tpad_pkg::MAG_W-1:0];
  assign ady      = ady_full[tpad_pkg::MAG_W-1:0];

  always_comb begin
    item_next.x           = tpad_pkg::XY_W'({adx, {tpad_pkg::GUARD_SHIFT{1'b0}}});
    item_next.y           = tpad_pkg::XY_W'({ady, {tpad_pkg::GUARD_SHIFT{1'b0}}});
    item_next.acc         = '0;
    item_next.meta.dx_neg = dx[tpad_pkg::DIFF_W-1];
    item_next.meta.dy_neg = dy[tpad_pkg::DIFF_W-1];
    // Settle the axes exactly; everything else goes round the CORDIC.
    priority if (dx == '0) begin
      item_next.meta.fixed = 1'b1;
      if (dy == '0) begin
        item_next.meta.fixed_angle = tpad_pkg::DEG0;
      end else if (dy[tpad_pkg::DIFF_W-1]) begin
        item_next.meta.fixed_angle = tpad_pkg::DEG270;
      end else begin
        item_next.meta.fixed_angle = tpad_pkg::DEG90;
      end
    end else if (dy == '0) begin
      item_next.meta.fixed       = 1'b1;
      item_next.meta.fixed_angle = dx[tpad_pkg::DIFF_W-1] ? tpad_pkg::DEG180 : tpad_pkg::DEG0;
    end else begin
      item_next.meta.fixed       = 1'b0;
      item_next.meta.fixed_angle = tpad_pkg::DEG0;
    end
  end

  // Advance when empty or when the next cell takes the word.
  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= item_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tpad_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point angle CORDIC cell
// One vectoring iteration: rotate towards the x axis and accumulate the
// matching arctangent, then hold the word for the next cell.
// ----------------------------------------------------------------------------
module tpad_cell (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [tpad_pkg::IDX_W-1:0] stage_idx,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire tpad_pkg::cord_t            in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tpad_pkg::cord_t                 out_data
);

  logic signed [tpad_pkg::XY_W-1:0]  x, y, xs, ys;
  logic signed [tpad_pkg::ACC_W-1:0] acc, step;
  tpad_pkg::cord_t                   item_next;
  logic                              vld;

  assign x    = in_data.x;
  assign y    = in_data.y;
  assign acc  = in_data.acc;
  assign xs   = x >>> stage_idx;
  assign ys   = y >>> stage_idx;
  assign step = {{(tpad_pkg::ACC_W-tpad_pkg::ATAN_W){1'b0}}, tpad_pkg::atan_entry(stage_idx)};

  always_comb begin
    item_next.meta = in_data.meta;
    if (!y[tpad_pkg::XY_W-1]) begin
      item_next.x   = x + ys;
      item_next.y   = y - xs;
      item_next.acc = acc + step;
    end else begin
      item_next.x   = x - ys;
      item_next.y   = y + xs;
      item_next.acc = acc - step;
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= item_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tpad_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point angle back end
// Rounds and clamps the accumulated angle, folds it into its quadrant and
// holds the result word for the consumer.
// ----------------------------------------------------------------------------
module tpad_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire tpad_pkg::cord_t              in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [tpad_pkg::ANGLE_W-1:0]      angle
);

  logic [tpad_pkg::ACC_W-1:0]   acc_pos;
  logic [tpad_pkg::ACC_W-1:0]   rounded;
  logic [tpad_pkg::ANGLE_W-1:0] quad_angle;
  logic [tpad_pkg::ANGLE_W-1:0] angle_next;
  logic                         vld;

  // Drop negative residue, round to 1/128 degree, clamp at a right angle.
  assign acc_pos = in_data.acc[tpad_pkg::ACC_W-1] ? '0 : in_data.acc;
  assign rounded = (acc_pos + tpad_pkg::ROUND_HALF) >> tpad_pkg::ACC_FRAC;
  assign quad_angle = (rounded > tpad_pkg::ACC_W'(tpad_pkg::DEG90)) ?
                      tpad_pkg::DEG90 : rounded[tpad_pkg::ANGLE_W-1:0];

  always_comb begin
    if (in_data.meta.fixed) begin
      angle_next = in_data.meta.fixed_angle;
    end else begin
      unique case ({in_data.meta.dx_neg, in_data.meta.dy_neg})
        2'b00: angle_next = quad_angle;
        2'b10: angle_next = tpad_pkg::DEG180 - quad_angle;
        2'b11: angle_next = tpad_pkg::DEG180 + quad_angle;
        // Fourth quadrant: a full turn wraps to zero
        default: angle_next = (quad_angle == '0) ? tpad_pkg::DEG0 :
                              tpad_pkg::DEG360 - quad_angle;
      endcase
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle <= angle_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tpad_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point angle checker
// Port-level properties of the angle unit, bound to the top level.
// ----------------------------------------------------------------------------
module tpad_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [tpad_pkg::ANGLE_W-1:0] angle
);

  // Every delivered angle lies below a full turn.
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle < tpad_pkg::DEG360))
    else $error("angle word at or above a full turn");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present straight after reset");

  // A draining consumer must open the input side through the ready chain.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output is drained");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(angle)))
    else $error("stalled result word changed or dropped");

endmodule

bind two_point_angle_degrees_unit tpad_checker u_tpad_checker (.*);
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Two-point angle unit testbench
// Feeds point pairs through the valid/ready front end, predicts each angle
// word with a bit-exact CORDIC of its own and compares the words in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tpad_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RANDOM_PAIRS = 1900;
  localparam int IDLE_PCT     = 14;
  localparam int MAX_REPORTS  = 10;
  // Quiet cycles allowed before giving up: well beyond any hold-off plus the
  // pipeline depth.
  localparam int QUIET_LIMIT  = 2000;
  // Cycles to wait after the last word so a stray extra word would show.
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLDOFF_LEN  = 150;

  typedef struct {
    logic [FIELD_W-1:0] bx;
    logic [FIELD_W-1:0] by;
    logic [FIELD_W-1:0] ex;
    logic [FIELD_W-1:0] ey;
  } point_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] begin_x   = '0;
  logic [FIELD_W-1:0] begin_y   = '0;
  logic [FIELD_W-1:0] end_x     = '0;
  logic [FIELD_W-1:0] end_y     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ANGLE_W-1:0] angle;

  point_pair_t        pending_pairs[$];
  logic [ANGLE_W-1:0] expected_angles[$];

  logic in_taken      = 1'b0;
  int   pairs_issued  = 0;
  int   angles_seen   = 0;
  int   mismatches    = 0;
  int   quiet_cycles  = 0;
  int   holdoff_left  = 0;
  int   next_holdoff  = 300;

  two_point_angle_degrees_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .begin_x   (begin_x),
    .begin_y   (begin_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle)
  );

  // --------------------------------------------------------------------------
  // Heading predictor
  // --------------------------------------------------------------------------

  // Take the low COORD_BITS of a field as a two's complement coordinate.
  function automatic longint coord_value(input logic [FIELD_W-1:0] raw);
    longint v;
    v = longint'(raw) & ((longint'(1) << COORD_BITS) - 1);
    if (v[COORD_BITS-1])
      v = v - (longint'(1) << COORD_BITS);
    return v;
  endfunction

  // atan(2^-i) in 2^-15 degree units, nearest integer.
  function automatic longint arctan_units(input int i);
    case (i)
      0:  return 1474560;
      1:  return 870484;
      2:  return 459940;
      3:  return 233473;
      4:  return 117189;
      5:  return 58652;
      6:  return 29333;
      7:  return 14667;
      8:  return 7334;
      9:  return 3667;
      10: return 1833;
      11: return 917;
      12: return 458;
      13: return 229;
      14: return 115;
      15: return 57;
      16: return 29;
      17: return 14;
      18: return 7;
      19: return 4;
      20: return 2;
      21: return 1;
      default: return 0;
    endcase
  endfunction

  // Vectoring-mode CORDIC on the magnitudes, folded to a first-quadrant angle
  // in 1/128 degree, clamped to [0, 90] degrees.
  function automatic longint quadrant_one_angle(input longint ax, input longint ay);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint acc;
    int     rounds;
    x      = ax <<< GUARD_SHIFT;
    y      = ay <<< GUARD_SHIFT;
    acc    = 0;
    rounds = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    for (int i = 0; i < rounds; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + arctan_units(i);
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - arctan_units(i);
      end
    end
    if (acc < 0)
      acc = 0;
    acc = (acc + 128) >>> ACC_FRAC;
    if (acc > longint'(DEG90))
      acc = longint'(DEG90);
    return acc;
  endfunction

  function automatic logic [ANGLE_W-1:0] heading_of(input point_pair_t p);
    longint dx;
    longint dy;
    longint a;
    longint res;
    dx = coord_value(p.ex) - coord_value(p.bx);
    dy = coord_value(p.ey) - coord_value(p.by);
    if (dx == 0) begin
      if (dy > 0)      res = longint'(DEG90);
      else if (dy < 0) res = longint'(DEG270);
      else             res = longint'(DEG0);
    end else if (dy == 0) begin
      res = (dx > 0) ? longint'(DEG0) : longint'(DEG180);
    end else begin
      a = quadrant_one_angle((dx < 0) ? -dx : dx, (dy < 0) ? -dy : dy);
      if (dx > 0 && dy > 0)      res = a;
      else if (dx < 0 && dy > 0) res = longint'(DEG180) - a;
      else if (dx < 0)           res = longint'(DEG180) + a;
      else                       res = longint'(DEG360) - a;
      // a zero angle in quadrant IV lands on a full turn
      if (res >= longint'(DEG360))
        res = res - longint'(DEG360);
    end
    return res[ANGLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  task automatic queue_pair(input int bx, input int by, input int ex, input int ey);
    point_pair_t p;
    p.bx = bx[FIELD_W-1:0];
    p.by = by[FIELD_W-1:0];
    p.ex = ex[FIELD_W-1:0];
    p.ey = ey[FIELD_W-1:0];
    pending_pairs.push_back(p);
  endtask

  task automatic queue_random_pairs();
    int bx;
    int by;
    int dx;
    int dy;
    int k;
    int pick;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      bx   = $urandom_range(65535);
      by   = $urandom_range(65535);
      pick = $urandom_range(99);
      if (pick < 40) begin
        // any pair at all: every field bit toggles here
        dx = $urandom_range(65535);
        dy = $urandom_range(65535);
      end else if (pick < 65) begin
        // short vectors, where rounding in the angle matters most
        dx = $urandom_range(128) - 64;
        dy = $urandom_range(128) - 64;
      end else if (pick < 80) begin
        // exact axes, including coincident points
        if ($urandom_range(1)) begin
          dx = 0;
          dy = ($urandom_range(3) == 0) ? 0 : $urandom_range(65535);
        end else begin
          dx = $urandom_range(65535);
          dy = 0;
        end
      end else if (pick < 90) begin
        // diagonals in all four quadrants
        k  = $urandom_range(32767) + 1;
        dx = $urandom_range(1) ? k : -k;
        dy = $urandom_range(1) ? k : -k;
      end else begin
        // just off an axis: tiny and saturated first-quadrant angles
        k  = $urandom_range(1) ? 1 : -1;
        if ($urandom_range(1)) begin
          dx = $urandom_range(65535);
          dy = k;
        end else begin
          dx = k;
          dy = $urandom_range(65535);
        end
      end
      queue_pair(bx, by, bx + dx, by + dy);
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and the main sequence
  // --------------------------------------------------------------------------

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    // coincident points, at the origin and elsewhere
    queue_pair(0, 0, 0, 0);
    queue_pair(100, -5, 100, -5);
    // vertical vectors, short and full span
    queue_pair(0, 0, 0, 7);
    queue_pair(0, 0, 0, -7);
    queue_pair(-32768, -32768, -32768, 32767);
    queue_pair(32767, 32767, 32767, -32768);
    // horizontal vectors, short and full span
    queue_pair(0, 0, 5, 0);
    queue_pair(0, 0, -5, 0);
    queue_pair(-32768, 0, 32767, 0);
    queue_pair(32767, 0, -32768, 0);
    // one point in each quadrant
    queue_pair(0, 0, 3, 4);
    queue_pair(0, 0, -3, 4);
    queue_pair(0, 0, -3, -4);
    queue_pair(0, 0, 3, -4);
    // diagonals at the extremes of the fields
    queue_pair(-32768, -32768, 32767, 32767);
    queue_pair(32767, -32768, -32768, 32767);
    queue_pair(32767, 32767, -32768, -32768);
    queue_pair(-32768, 32767, 32767, -32768);
    queue_pair(-1, -1, 0, 0);
    queue_pair(1, 0, 0, 1);
    // nearly flat in quadrant IV: the angle rounds to a full turn and wraps
    queue_pair(-32768, 0, 32767, -1);
    // nearly vertical: the first-quadrant angle saturates at 90 degrees
    queue_pair(0, -32768, 1, 32767);
    queue_pair(0, 32767, -1, -32768);
    queue_random_pairs();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: every pair sent, every angle word back, then a quiet tail
    while (pending_pairs.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_angles.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_angles.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: give up once nothing has moved on either side for too long.
  initial begin
    while (quiet_cycles < QUIET_LIMIT)
      @(posedge clk);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    point_pair_t p;
    logic        calm;
    calm = (pairs_issued >= 700) && (pairs_issued < 1000);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold the word until the unit takes it
    end else if (pending_pairs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
      p = pending_pairs.pop_front();
      begin_x      <= p.bx;
      begin_y      <= p.by;
      end_x        <= p.ex;
      end_y        <= p.ey;
      in_valid     <= 1'b1;
      pairs_issued <= pairs_issued + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, a calm stretch lined up with the sender's, and a
  // long hold-off now and then so the pipeline fills and pushes back on the
  // sender.
  always @(negedge clk) begin
    logic calm;
    calm = (angles_seen >= 700) && (angles_seen < 1000);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      out_ready    <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (angles_seen >= next_holdoff) begin
      out_ready    <= 1'b0;
      holdoff_left <= HOLDOFF_LEN;
      next_holdoff <= next_holdoff + 1200;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict on input, check on output
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    point_pair_t        p;
    logic [ANGLE_W-1:0] want;
    logic               in_fire;
    logic               out_fire;
    in_fire  = !rst && in_valid && in_ready;
    out_fire = !rst && out_valid && out_ready;
    in_taken <= in_fire;
    quiet_cycles <= (in_fire || out_fire) ? 0 : quiet_cycles + 1;

    if (in_fire) begin
      p.bx = begin_x;
      p.by = begin_y;
      p.ex = end_x;
      p.ey = end_y;
      expected_angles.push_back(heading_of(p));
    end

    if (out_fire) begin
      angles_seen <= angles_seen + 1;
      if (expected_angles.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("angle word %0d arrived with none expected: %0d",
                   angles_seen, angle);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_angles.pop_front();
        if (angle !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("angle word %0d: expected %0d, got %0d",
                     angles_seen, want, angle);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

endmodule

[files.f]
hw/rtl/tpad_pkg.sv
hw/rtl/tpad_front.sv
hw/rtl/tpad_cell.sv
hw/rtl/tpad_back.sv
hw/rtl/two_point_angle_degrees_unit.sv
hw/rtl/tpad_checker.sv
tb/testbench.sv
